[design/lfu_cache_table_macros.svh]
// Assertion macros for the lfu_cache_table block.
// Included by RTL modules that check their own logic; needs clk and rst_n in scope.
`ifndef LFU_CACHE_TABLE_MACROS_SVH
`define LFU_CACHE_TABLE_MACROS_SVH

// Check a same-cycle implication under reset.
`define LFU_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a next-cycle implication under reset.
`define LFU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/lfu_pkg.sv]
// Package for the lfu_cache_table block: sizes, codes and controller/datapath types.
// No dependencies.
package lfu_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W  = IDX_W;
    localparam int OCC_W   = $clog2(ENTRIES + 1);
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int CNT_W   = 32;
    localparam int CAP_W   = 5;
    localparam int CMP_W   = (CAP_W > OCC_W) ? CAP_W : OCC_W;
    localparam int PDATA_W = 32;
    localparam int PADDR_W = 3;

    localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_PUT = 1'b1;

    localparam logic REG_CAPACITY = 1'b0;

    typedef struct packed {
        logic start;
        logic scan;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } status_t;

endpackage

[design/lfu_ifs.sv]
// Request and response channel interfaces for the lfu_cache_table block.
// Depends on lfu_pkg for field widths.
interface lfu_req_if;
    logic                      valid;
    logic                      ready;
    logic                      func;
    logic [lfu_pkg::KEY_W-1:0] key;
    logic [lfu_pkg::VAL_W-1:0] value;

    modport source (output valid, output func, output key, output value, input ready);
    modport sink   (input valid, input func, input key, input value, output ready);
endinterface

interface lfu_rsp_if;
    logic                      valid;
    logic                      ready;
    logic                      found;
    logic [lfu_pkg::VAL_W-1:0] read_value;
    logic                      evicted;
    logic [lfu_pkg::KEY_W-1:0] evicted_key;

    modport source (output valid, output found, output read_value, output evicted,
                    output evicted_key, input ready);
    modport sink   (input valid, input found, input read_value, input evicted,
                    input evicted_key, output ready);
endinterface

[design/lfu_ctrl.sv]
// Controller for the lfu_cache_table block: sequences accept, scan, drain and commit.
// Depends on lfu_pkg for cmd_t and status_t.
module lfu_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  lfu_pkg::status_t status,
    output lfu_pkg::cmd_t    cmd
);
    import lfu_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready  = (state_reg == ST_IDLE);
    assign cmd.start  = (state_reg == ST_IDLE) && req_valid;
    assign cmd.scan   = (state_reg == ST_SCAN);
    assign cmd.commit = (state_reg == ST_FINISH) && status.out_free;

endmodule

[design/lfu_dpath.sv]
// Datapath for the lfu_cache_table block: entry stores, scan trackers, update and result beat.
// Depends on lfu_pkg and lfu_cache_table_macros.svh.
`include "lfu_cache_table_macros.svh"

module lfu_dpath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  lfu_pkg::cmd_t             cmd,
    output lfu_pkg::status_t          status,
    input  logic [lfu_pkg::CAP_W-1:0] capacity,
    input  logic                      func,
    input  logic [lfu_pkg::KEY_W-1:0] key,
    input  logic [lfu_pkg::VAL_W-1:0] value,
    output logic                      rsp_valid,
    input  logic                      rsp_ready,
    output logic                      found,
    output logic [lfu_pkg::VAL_W-1:0] read_value,
    output logic                      evicted,
    output logic [lfu_pkg::KEY_W-1:0] evicted_key
);
    import lfu_pkg::*;

    logic [KEY_W-1:0]  key_mem [ENTRIES];
    logic [VAL_W-1:0]  val_mem [ENTRIES];
    logic [CNT_W-1:0]  cnt_mem [ENTRIES];
    logic [RANK_W-1:0] rank_reg [ENTRIES];
    logic [RANK_W-1:0] rank_next [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;

    logic             func_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] value_reg;

    logic [IDX_W-1:0] scan_idx_reg;
    logic             chk_vld_reg;
    logic [IDX_W-1:0] chk_idx_reg;
    logic [KEY_W-1:0] rd_key_reg;
    logic [VAL_W-1:0] rd_val_reg;
    logic [CNT_W-1:0] rd_cnt_reg;

    logic              hit_reg;
    logic [IDX_W-1:0]  hit_idx_reg;
    logic [VAL_W-1:0]  hit_val_reg;
    logic [CNT_W-1:0]  hit_cnt_reg;
    logic [RANK_W-1:0] hit_rank_reg;
    logic [OCC_W-1:0]  occ_reg;
    logic              vic_found_reg;
    logic [IDX_W-1:0]  vic_idx_reg;
    logic [CNT_W-1:0]  vic_cnt_reg;
    logic [RANK_W-1:0] vic_rank_reg;
    logic [KEY_W-1:0]  vic_key_reg;

    logic             out_valid_reg;
    logic             found_reg;
    logic [VAL_W-1:0] read_value_reg;
    logic             evicted_reg;
    logic [KEY_W-1:0] evicted_key_reg;

    logic [CMP_W-1:0]   cap_ext;
    logic [CMP_W-1:0]   cap_eff;
    logic               do_bump;
    logic               do_put_new;
    logic               do_evict;
    logic [ENTRIES-1:0] valid_after;
    logic               slot_found;
    logic [IDX_W-1:0]   slot_idx;
    logic [CNT_W-1:0]   cnt_bumped;
    logic [IDX_W-1:0]   wr_idx;
    logic               wr_cnt;
    logic               wr_val;
    logic               wr_key;
    logic [CNT_W-1:0]   wr_cnt_data;
    logic [RANK_W-1:0]  cur_rank;
    logic               chk_entry_valid;
    logic               take_victim;

    // Effective capacity and commit decisions
    always_comb
    begin
        cap_ext    = CMP_W'(capacity);
        cap_eff    = (cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext;
        do_bump    = hit_reg && ((func_reg == FUNC_GET) || (cap_eff != '0));
        do_put_new = !hit_reg && (func_reg == FUNC_PUT) && (cap_eff != '0);
        do_evict   = do_put_new && (CMP_W'(occ_reg) >= cap_eff) && vic_found_reg;
        cnt_bumped = (hit_cnt_reg == CNT_MAX) ? hit_cnt_reg : hit_cnt_reg + CNT_W'(1);
    end

    // Free slot after a possible eviction, lowest index first
    always_comb
    begin
        valid_after = valid_reg;
        if (do_evict)
        begin
            valid_after[vic_idx_reg] = 1'b0;
        end
        slot_found = 1'b0;
        slot_idx   = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_after[i])
            begin
                slot_found = 1'b1;
                slot_idx   = IDX_W'(i);
            end
        end
    end

    // Rank and valid update at commit
    always_comb
    begin
        valid_next = valid_reg;
        for (int i = 0; i < ENTRIES; i++)
        begin
            rank_next[i] = rank_reg[i];
            if (cmd.commit && do_bump)
            begin
                if (IDX_W'(i) == hit_idx_reg)
                begin
                    rank_next[i] = '0;
                end
                else if (valid_reg[i] && (rank_reg[i] < hit_rank_reg))
                begin
                    rank_next[i] = rank_reg[i] + RANK_W'(1);
                end
            end
            else if (cmd.commit && do_put_new && slot_found)
            begin
                if (IDX_W'(i) == slot_idx)
                begin
                    rank_next[i] = '0;
                end
                else if (valid_after[i])
                begin
                    if (do_evict && (rank_reg[i] > vic_rank_reg))
                    begin
                        rank_next[i] = rank_reg[i];
                    end
                    else
                    begin
                        rank_next[i] = rank_reg[i] + RANK_W'(1);
                    end
                end
            end
        end
        if (cmd.commit && do_put_new)
        begin
            valid_next = valid_after;
            if (slot_found)
            begin
                valid_next[slot_idx] = 1'b1;
            end
        end
    end

    always_comb
    begin
        wr_idx      = do_bump ? hit_idx_reg : slot_idx;
        wr_cnt      = cmd.commit && (do_bump || (do_put_new && slot_found));
        wr_val      = cmd.commit && ((do_bump && (func_reg == FUNC_PUT))
                                     || (do_put_new && slot_found));
        wr_key      = cmd.commit && do_put_new && slot_found;
        wr_cnt_data = do_bump ? cnt_bumped : CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (wr_key)
        begin
            key_mem[wr_idx] <= key_reg;
        end
        if (cmd.scan)
        begin
            rd_key_reg <= key_mem[scan_idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_val)
        begin
            val_mem[wr_idx] <= value_reg;
        end
        if (cmd.scan)
        begin
            rd_val_reg <= val_mem[scan_idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_cnt)
        begin
            cnt_mem[wr_idx] <= wr_cnt_data;
        end
        if (cmd.scan)
        begin
            rd_cnt_reg <= cnt_mem[scan_idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            rank_reg[i] <= rank_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Scan address and read pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            chk_vld_reg  <= 1'b0;
            chk_idx_reg  <= '0;
        end
        else
        begin
            chk_vld_reg <= cmd.scan;
            chk_idx_reg <= scan_idx_reg;
            if (cmd.start)
            begin
                scan_idx_reg <= '0;
            end
            else if (cmd.scan)
            begin
                scan_idx_reg <= scan_idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            func_reg  <= func;
            key_reg   <= key;
            value_reg <= value;
        end
    end

    always_comb
    begin
        cur_rank        = rank_reg[chk_idx_reg];
        chk_entry_valid = chk_vld_reg && valid_reg[chk_idx_reg];
        take_victim     = !vic_found_reg || (rd_cnt_reg < vic_cnt_reg)
                          || ((rd_cnt_reg == vic_cnt_reg) && (cur_rank > vic_rank_reg));
    end

    // Hit, occupancy and victim trackers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg       <= 1'b0;
            occ_reg       <= '0;
            vic_found_reg <= 1'b0;
        end
        else if (cmd.start)
        begin
            hit_reg       <= 1'b0;
            occ_reg       <= '0;
            vic_found_reg <= 1'b0;
        end
        else if (chk_entry_valid)
        begin
            occ_reg <= occ_reg + OCC_W'(1);
            if (!hit_reg && (rd_key_reg == key_reg))
            begin
                hit_reg <= 1'b1;
            end
            if (take_victim)
            begin
                vic_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (chk_entry_valid && !hit_reg && (rd_key_reg == key_reg))
        begin
            hit_idx_reg  <= chk_idx_reg;
            hit_val_reg  <= rd_val_reg;
            hit_cnt_reg  <= rd_cnt_reg;
            hit_rank_reg <= cur_rank;
        end
        if (chk_entry_valid && take_victim)
        begin
            vic_idx_reg  <= chk_idx_reg;
            vic_cnt_reg  <= rd_cnt_reg;
            vic_rank_reg <= cur_rank;
            vic_key_reg  <= rd_key_reg;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            found_reg       <= hit_reg;
            read_value_reg  <= (hit_reg && (func_reg == FUNC_GET)) ? hit_val_reg : '0;
            evicted_reg     <= do_evict;
            evicted_key_reg <= do_evict ? vic_key_reg : '0;
        end
    end

    assign status.scan_last = (scan_idx_reg == IDX_W'(ENTRIES - 1));
    assign status.out_free  = !out_valid_reg || rsp_ready;

    assign rsp_valid   = out_valid_reg;
    assign found       = found_reg;
    assign read_value  = read_value_reg;
    assign evicted     = evicted_reg;
    assign evicted_key = evicted_key_reg;

    `LFU_ASSERT_IMPL(a_insert_slot, cmd.commit && do_put_new, slot_found, "no free slot on insert")
    `LFU_ASSERT_IMPL(a_victim_live, cmd.commit && do_evict, valid_reg[vic_idx_reg], "victim not valid")
    `LFU_ASSERT_IMPL(a_commit_free, cmd.commit, !out_valid_reg || rsp_ready, "result overwritten")
    `LFU_ASSERT_NEXT(a_commit_out, cmd.commit, out_valid_reg, "result beat not raised")

endmodule

[design/lfu_cache_table.sv]
// A request beat starts the entry scan reads, then a drain step and the commit of the response.
// Requests are taken only in idle, after the last commit; the scan reads through the single
// read port of the key/value/count memories; a waiting response beat holds the commit cycle.
// Reset: valid bits and control clear at once, capacity returns to 16; no clearing pass.
// Top level of the lfu_cache_table block: APB register, controller and datapath.
// Depends on lfu_pkg, lfu_ifs, lfu_ctrl and lfu_dpath.
module lfu_cache_table (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lfu_pkg::PADDR_W-1:0] paddr,
    input  logic [lfu_pkg::PDATA_W-1:0] pwdata,
    output logic [lfu_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    lfu_req_if.sink                     req,
    lfu_rsp_if.source                   rsp
);
    import lfu_pkg::*;

    logic [CAP_W-1:0] capacity_reg;
    logic             reg_sel;
    cmd_t             cmd;
    status_t          status;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (psel && penable && pwrite && (reg_sel == REG_CAPACITY))
        begin
            capacity_reg <= pwdata[CAP_W-1:0];
        end
    end

    assign prdata = (reg_sel == REG_CAPACITY) ? PDATA_W'(capacity_reg) : '0;

    lfu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .status    (status),
        .cmd       (cmd)
    );

    lfu_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .capacity    (capacity_reg),
        .func        (req.func),
        .key         (req.key),
        .value       (req.value),
        .rsp_valid   (rsp.valid),
        .rsp_ready   (rsp.ready),
        .found       (rsp.found),
        .read_value  (rsp.read_value),
        .evicted     (rsp.evicted),
        .evicted_key (rsp.evicted_key)
    );

endmodule
